>>> design/rsfa_pkg.sv
// Shared types, constants and register codes for the range sensor filter.
`timescale 1ns / 1ps
`default_nettype none

package rsfa_pkg;

  // Field and port widths
  localparam int DIST_W      = 13;
  localparam int CH_W        = 2;
  localparam int CNT_W       = 8;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 13;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 16;

  // Default sizing of the filter
  localparam int DEF_WINDOW_LEN = 6;
  localparam int DEF_CHANNELS   = 3;

  // Reset values
  localparam logic [DIST_W-1:0] DIST_RESET      = 13'd4800;
  localparam logic [DIST_W-1:0] THR_FRONT_RESET = 13'd1600;
  localparam logic [DIST_W-1:0] THR_SIDE_RESET  = 13'd960;
  localparam logic [DIST_W-1:0] RANGE_MIN_RESET = 13'd320;
  localparam logic [DIST_W-1:0] RANGE_MAX_RESET = 13'd4800;
  localparam logic [DIST_W-1:0] JUMP_RESET      = 13'd800;
  localparam logic [CNT_W-1:0]  ALARM_ON_RESET  = 8'd2;
  localparam logic [CNT_W-1:0]  ALARM_OFF_RESET = 8'd3;
  localparam logic [CNT_W-1:0]  CNT_MAX         = 8'd255;

  // Blend weights for a large jump, scaled by 256
  localparam int BLEND_LAST_WT = 179;
  localparam int BLEND_RAW_WT  = 77;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THR_FRONT,
    REG_THR_LEFT,
    REG_THR_RIGHT,
    REG_RANGE_MIN,
    REG_RANGE_MAX,
    REG_JUMP_LIMIT,
    REG_ALARM_ON,
    REG_ALARM_OFF
  } cfg_reg_t;

  // Channel codes that pick a dedicated threshold
  localparam logic [CH_W-1:0] CH_FRONT = 2'd0;
  localparam logic [CH_W-1:0] CH_LEFT  = 2'd1;

  typedef struct packed {
    logic [DIST_W-1:0] thr_front;
    logic [DIST_W-1:0] thr_left;
    logic [DIST_W-1:0] thr_right;
    logic [DIST_W-1:0] range_min;
    logic [DIST_W-1:0] range_max;
    logic [DIST_W-1:0] jump_limit;
    logic [CNT_W-1:0]  raise_cnt;
    logic [CNT_W-1:0]  clear_cnt;
  } cfg_t;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SUM,
    S_MUL,
    S_FIN
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic sum;
    logic mul;
    logic fin;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

>>> design/rsfa_cfg.sv
// Configuration register file of the range sensor filter.
`timescale 1ns / 1ps
`default_nettype none

module rsfa_cfg (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [rsfa_pkg::CFG_IDX_W-1:0]   cfg_addr,
  input  wire logic [rsfa_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output rsfa_pkg::cfg_t                        cfg
);
  import rsfa_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Decode a write into the addressed register
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_THR_FRONT:  cfg_nxt.thr_front  = cfg_wdata[DIST_W-1:0];
        REG_THR_LEFT:   cfg_nxt.thr_left   = cfg_wdata[DIST_W-1:0];
        REG_THR_RIGHT:  cfg_nxt.thr_right  = cfg_wdata[DIST_W-1:0];
        REG_RANGE_MIN:  cfg_nxt.range_min  = cfg_wdata[DIST_W-1:0];
        REG_RANGE_MAX:  cfg_nxt.range_max  = cfg_wdata[DIST_W-1:0];
        REG_JUMP_LIMIT: cfg_nxt.jump_limit = cfg_wdata[DIST_W-1:0];
        REG_ALARM_ON:   cfg_nxt.raise_cnt  = cfg_wdata[CNT_W-1:0];
        REG_ALARM_OFF:  cfg_nxt.clear_cnt  = cfg_wdata[CNT_W-1:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  // Hold the registers, load reset values
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.thr_front  <= THR_FRONT_RESET;
      cfg_r.thr_left   <= THR_SIDE_RESET;
      cfg_r.thr_right  <= THR_SIDE_RESET;
      cfg_r.range_min  <= RANGE_MIN_RESET;
      cfg_r.range_max  <= RANGE_MAX_RESET;
      cfg_r.jump_limit <= JUMP_RESET;
      cfg_r.raise_cnt  <= ALARM_ON_RESET;
      cfg_r.clear_cnt  <= ALARM_OFF_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

>>> design/rsfa_ctrl.sv
// Sequencer that steps each request through the filter datapath.
`timescale 1ns / 1ps
`default_nettype none

module rsfa_ctrl (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  rsfa_pkg::sts_t  sts,
  output rsfa_pkg::cmd_t  cmd
);
  import rsfa_pkg::*;

  state_t state_r;
  state_t state_nxt;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_tvalid) state_nxt = S_SUM;
      S_SUM:   state_nxt = S_MUL;
      S_MUL:   state_nxt = S_FIN;
      S_FIN:   if (sts.out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    in_tready = 1'b0;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      S_SUM:   cmd.sum = 1'b1;
      S_MUL:   cmd.mul = 1'b1;
      S_FIN:   cmd.fin = sts.out_free;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

>>> design/rsfa_dp.sv
// Filter datapath: range check, jump blend, window average, EMA and alarm.
`timescale 1ns / 1ps
`default_nettype none

module rsfa_dp #(
  parameter int WINDOW_LEN = rsfa_pkg::DEF_WINDOW_LEN,
  parameter int CHANNELS   = rsfa_pkg::DEF_CHANNELS
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  rsfa_pkg::cfg_t                          cfg,
  input  rsfa_pkg::cmd_t                          cmd,
  output rsfa_pkg::sts_t                          sts,
  input  wire logic [rsfa_pkg::IN_TDATA_W-1:0]    in_tdata,   // [12:0] raw_distance
  input  wire logic [rsfa_pkg::CH_W-1:0]          in_tuser,   // [1:0] channel
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  output logic [rsfa_pkg::OUT_TDATA_W-1:0]        out_tdata,  // [12:0] filtered, [13] alarm
  output logic [rsfa_pkg::CH_W-1:0]               out_tuser   // [1:0] out_channel
);
  import rsfa_pkg::*;

  localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int POS_W    = $clog2(WINDOW_LEN);
  localparam int DEPTH    = CHANNELS * WINDOW_LEN;
  localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SUM_W    = DIST_W + $clog2(WINDOW_LEN);
  localparam int SHIFT    = SUM_W + $clog2(WINDOW_LEN);
  localparam int RECIP_W  = SUM_W + 1;
  localparam int PROD_W   = SUM_W + RECIP_W;
  localparam int BLEND_W  = DIST_W + 8;
  localparam int EMA_W    = DIST_W + 2;
  localparam int PAD_W    = OUT_TDATA_W - DIST_W - 1;
  // Reciprocal that gives an exact floor for every sum below 2**SUM_W
  localparam longint unsigned RECIP =
      ((64'd1 << SHIFT) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN);
  localparam logic [RECIP_W-1:0] RECIP_V   = RECIP_W'(RECIP);
  localparam logic [SUM_W-1:0]   SUM_RESET = SUM_W'(WINDOW_LEN) * SUM_W'(DIST_RESET);
  localparam logic [POS_W-1:0]   POS_LAST  = POS_W'(WINDOW_LEN - 1);

  // Per-channel state
  logic [DIST_W-1:0] last_good_r [CHANNELS];
  logic [POS_W-1:0]  pos_r       [CHANNELS];
  logic [SUM_W-1:0]  win_sum_r   [CHANNELS];
  logic [DIST_W-1:0] smoothed_r  [CHANNELS];
  logic [CNT_W-1:0]  below_r     [CHANNELS];
  logic [CNT_W-1:0]  above_r     [CHANNELS];
  logic              alarm_r     [CHANNELS];

  // Window memory and its written marks
  logic [DIST_W-1:0] win_mem [DEPTH];
  logic [DEPTH-1:0]  win_vld_r;
  logic [DIST_W-1:0] rd_data_r;
  logic              rd_vld_r;

  // Request held through the steps
  logic [CH_W-1:0]     ch_r;
  logic                ok_r;
  logic [CH_IDX_W-1:0] idx_r;
  logic [DIST_W-1:0]   val_r;
  logic [ADDR_W-1:0]   addr_r;
  logic [SUM_W-1:0]    acc_r;
  logic [PROD_W-1:0]   prod_r;

  // Result register
  logic              out_valid_r;
  logic [CH_W-1:0]   out_ch_r;
  logic [DIST_W-1:0] out_dist_r;
  logic              out_alarm_r;

  // Load step signals
  logic [DIST_W-1:0]   raw;
  logic                in_ok;
  logic [CH_IDX_W-1:0] sel_idx;
  logic [DIST_W-1:0]   lg;
  logic                reject;
  logic [DIST_W-1:0]   diff;
  logic [BLEND_W-1:0]  blend_full;
  logic [DIST_W-1:0]   val_nxt;
  logic [ADDR_W-1:0]   addr_nxt;

  // Sum step signals
  logic [DIST_W-1:0] old_val;
  logic [SUM_W-1:0]  sum_nxt;
  logic [POS_W-1:0]  pos_cur;
  logic [POS_W-1:0]  pos_nxt;

  // Finish step signals
  logic [DIST_W-1:0] mean;
  logic [DIST_W-1:0] sm_cur;
  logic [EMA_W-1:0]  ema_full;
  logic [DIST_W-1:0] ema_nxt;
  logic [DIST_W-1:0] thr;
  logic              is_below;
  logic [CNT_W-1:0]  below_inc;
  logic [CNT_W-1:0]  above_inc;
  logic              alarm_nxt;

  // Range check and jump blend on the incoming request
  always_comb begin
    raw      = in_tdata[DIST_W-1:0];
    in_ok    = int'(in_tuser) < CHANNELS;
    sel_idx  = in_ok ? CH_IDX_W'(in_tuser) : '0;
    lg       = last_good_r[sel_idx];
    reject   = (raw == '0) || (raw < cfg.range_min) || (raw > cfg.range_max);
    diff     = (raw > lg) ? (raw - lg) : (lg - raw);
    blend_full = BLEND_W'(BLEND_LAST_WT) * BLEND_W'(lg)
               + BLEND_W'(BLEND_RAW_WT) * BLEND_W'(raw);
    if (reject) begin
      val_nxt = lg;
    end else if (diff > cfg.jump_limit) begin
      val_nxt = blend_full[BLEND_W-1:8];
    end else begin
      val_nxt = raw;
    end
    addr_nxt = ADDR_W'(sel_idx) * ADDR_W'(WINDOW_LEN) + ADDR_W'(pos_r[sel_idx]);
  end

  // Running window sum: drop the old entry, add the new one
  always_comb begin
    old_val = rd_vld_r ? rd_data_r : DIST_RESET;
    sum_nxt = win_sum_r[idx_r] - SUM_W'(old_val) + SUM_W'(val_r);
    pos_cur = pos_r[idx_r];
    pos_nxt = (pos_cur == POS_LAST) ? '0 : pos_cur + POS_W'(1);
  end

  // EMA and hysteresis alarm
  always_comb begin
    mean      = DIST_W'(prod_r >> SHIFT);
    sm_cur    = smoothed_r[idx_r];
    ema_full  = EMA_W'(3) * EMA_W'(sm_cur) + EMA_W'(mean);
    ema_nxt   = ema_full[EMA_W-1:2];
    if (ch_r == CH_FRONT) begin
      thr = cfg.thr_front;
    end else if (ch_r == CH_LEFT) begin
      thr = cfg.thr_left;
    end else begin
      thr = cfg.thr_right;
    end
    is_below  = ema_nxt < thr;
    below_inc = (below_r[idx_r] == CNT_MAX) ? CNT_MAX : below_r[idx_r] + CNT_W'(1);
    above_inc = (above_r[idx_r] == CNT_MAX) ? CNT_MAX : above_r[idx_r] + CNT_W'(1);
    alarm_nxt = alarm_r[idx_r];
    if (is_below) begin
      if (below_inc >= cfg.raise_cnt) alarm_nxt = 1'b1;
    end else begin
      if (above_inc >= cfg.clear_cnt) alarm_nxt = 1'b0;
    end
  end

  // Window memory: read on load, write on sum
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rd_data_r <= win_mem[addr_nxt];
      rd_vld_r  <= win_vld_r[addr_nxt];
    end
    if (cmd.sum && ok_r) begin
      win_mem[addr_r] <= val_r;
    end
  end

  // Request payload through the steps
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ch_r   <= in_tuser;
      ok_r   <= in_ok;
      idx_r  <= sel_idx;
      val_r  <= val_nxt;
      addr_r <= addr_nxt;
    end
    if (cmd.sum) begin
      acc_r <= sum_nxt;
    end
    if (cmd.mul) begin
      prod_r <= PROD_W'(acc_r) * PROD_W'(RECIP_V);
    end
    if (cmd.fin) begin
      out_ch_r    <= ch_r;
      out_dist_r  <= ok_r ? ema_nxt : '0;
      out_alarm_r <= ok_r & alarm_nxt;
    end
  end

  // Per-channel state updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < CHANNELS; c++) begin
        last_good_r[c] <= DIST_RESET;
        pos_r[c]       <= '0;
        win_sum_r[c]   <= SUM_RESET;
        smoothed_r[c]  <= DIST_RESET;
        below_r[c]     <= '0;
        above_r[c]     <= '0;
        alarm_r[c]     <= 1'b0;
      end
      win_vld_r <= '0;
    end else begin
      if (cmd.load && in_ok && !reject) begin
        last_good_r[sel_idx] <= val_nxt;
      end
      if (cmd.sum && ok_r) begin
        win_sum_r[idx_r] <= sum_nxt;
        pos_r[idx_r]     <= pos_nxt;
        win_vld_r[addr_r] <= 1'b1;
      end
      if (cmd.fin && ok_r) begin
        smoothed_r[idx_r] <= ema_nxt;
        below_r[idx_r]    <= is_below ? below_inc : '0;
        above_r[idx_r]    <= is_below ? '0 : above_inc;
        alarm_r[idx_r]    <= alarm_nxt;
      end
    end
  end

  // Output valid: set on finish, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.fin) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign sts.out_free  = !out_valid_r || out_tready;
  assign out_tvalid    = out_valid_r;
  assign out_tdata     = {PAD_W'(0), out_alarm_r, out_dist_r};
  assign out_tuser     = out_ch_r;

endmodule

`default_nettype wire

>>> design/range_sensor_filter_alarm.sv
// A result becomes valid in the output register after its request has gone through the
// load, sum, multiply and finish steps; finish waits until the output register is free.
// The next request is taken only once the previous one has left the finish step.
// A finished result waits in the output register while the next request is taken.
// Reset: synchronous, active low; all channel state returns to its reset values
// (window entries through per-entry valid bits), with no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module range_sensor_filter_alarm #(
  parameter int WINDOW_LEN = rsfa_pkg::DEF_WINDOW_LEN,
  parameter int CHANNELS   = rsfa_pkg::DEF_CHANNELS
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [rsfa_pkg::IN_TDATA_W-1:0]    in_tdata,   // [12:0] raw_distance
  input  wire logic [rsfa_pkg::CH_W-1:0]          in_tuser,   // [1:0] channel
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  output logic [rsfa_pkg::OUT_TDATA_W-1:0]        out_tdata,  // [12:0] filtered, [13] alarm
  output logic [rsfa_pkg::CH_W-1:0]               out_tuser,  // [1:0] out_channel
  input  wire logic                               cfg_we,
  input  wire logic [rsfa_pkg::CFG_IDX_W-1:0]     cfg_addr,
  input  wire logic [rsfa_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import rsfa_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  rsfa_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  rsfa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rsfa_dp #(
    .WINDOW_LEN (WINDOW_LEN),
    .CHANNELS   (CHANNELS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire
